FILE: rtl/core/rtpq_pkg.sv
// Package for the task priority queue manager: sizes, codes and types.
// No dependencies.
package rtpq_pkg;
	localparam int TASK_SLOTS = 8;
	localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CNT_W = $clog2(TASK_SLOTS + 1);

	localparam logic [2:0] OP_CREATE = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_STOP = 3'd2;
	localparam logic [2:0] OP_EXIT = 3'd3;
	localparam logic [2:0] OP_ENQ = 3'd4;
	localparam logic [2:0] OP_DEQ = 3'd5;
	localparam logic [2:0] OP_REMOVE = 3'd6;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_PARAM = 2'd1;
	localparam logic [1:0] ST_NOSLOT = 2'd2;
	localparam logic [1:0] ST_HANDLE = 2'd3;

	localparam logic [2:0] Q_RUN = 3'd0;
	localparam logic [2:0] Q_READY = 3'd1;
	localparam logic [2:0] Q_DORMANT = 3'd3;
	localparam logic [2:0] Q_NONE = 3'd4;

	localparam logic [1:0] CFG_CHECK = 2'd0;
	localparam logic [1:0] CFG_PMIN = 2'd1;
	localparam logic [1:0] CFG_PMAX = 2'd2;

	typedef struct packed {
		logic              clear;
		logic              load;
		logic [SLOT_W-1:0] idx;
		logic              in_use;
		logic [2:0]        queue;
		logic [7:0]        prio;
		logic              older_bit;
	} scan_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] best;
	} scan_res_t;
endpackage

FILE: rtl/core/rtpq_scan.sv
// Shared scan unit: walks one slot per cycle, tracking the first free slot or
// the queue head. Depends on rtpq_pkg.
module rtpq_scan import rtpq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      mode_free,
	input  logic [2:0] target_q,
	input  scan_t     ctl,
	output scan_res_t res
);
	logic [7:0] best_pri_q;
	logic       hit;
	logic       better;

	always_comb begin
		if (mode_free) begin
			hit = !ctl.in_use;
			better = !res.found;
		end else begin
			hit = ctl.in_use && (ctl.queue == target_q);
			better = !res.found || (ctl.prio < best_pri_q) ||
				((ctl.prio == best_pri_q) && ctl.older_bit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res <= '0;
			best_pri_q <= '0;
		end else if (ctl.clear) begin
			res <= '0;
		end else if (ctl.load && hit && better) begin
			res.found <= 1'b1;
			res.best <= ctl.idx;
			best_pri_q <= ctl.prio;
		end
	end
endmodule

FILE: rtl/core/rtos_task_priority_queue_manager_unit.sv
// Top level of the task priority queue manager: slot table, sequencer and
// result register. Depends on rtpq_pkg and rtpq_scan.
//
// Usage: pulse start with op and its operands while busy is low. The block
// raises busy, works the command, then shows status, result_task,
// result_valid and last_error for one cycle with done high. Create, exit and
// dequeue walk all TASK_SLOTS slots through the scan unit, one slot a cycle,
// before they execute. Start, stop, enqueue and remove execute without a
// scan. A new command may be given in the cycle done is high. The receiver
// cannot stall; each result beat is shown once. Configuration writes
// (cfg_we, cfg_index, cfg_data) take effect at once; the user must make
// them only while busy is low; the block does not enforce this. Reset empties
// the table, clears the stored error and restores the configuration defaults.
module rtos_task_priority_queue_manager_unit import rtpq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  op,
	input  logic [3:0]  task_index,
	input  logic [1:0]  queue_select,
	input  logic [7:0]  priority_req,
	input  logic [31:0] entry_address,
	input  logic [31:0] stack_length,
	input  logic [31:0] stack_base,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        done,
	output logic [1:0]  status,
	output logic [3:0]  result_task,
	output logic        result_valid,
	output logic [1:0]  last_error
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_EXEC = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [2:0]  op_q;
	logic [3:0]  task_q;
	logic [1:0]  qsel_q;
	logic [7:0]  pri_q;
	logic [31:0] entry_q, slen_q, sbase_q;
	logic        chk_q;
	logic [7:0]  pmin_q, pmax_q;
	logic [1:0]  err_q;

	logic [TASK_SLOTS-1:0] in_use_q;
	logic [7:0]            prio_q [TASK_SLOTS];
	logic [2:0]            queue_q [TASK_SLOTS];
	logic [TASK_SLOTS-1:0] older_q [TASK_SLOTS];
	logic [31:0]           sentry_q [TASK_SLOTS];
	logic [31:0]           sslen_q [TASK_SLOTS];
	logic [31:0]           ssbase_q [TASK_SLOTS];

	scan_t     sc;
	scan_res_t sr;
	logic      mode_free;
	logic [2:0] target_q;
	logic [SLOT_W-1:0] sidx;
	logic       handle_ok;
	logic [SLOT_W-1:0] tidx;
	logic       param_bad;

	assign sidx = cnt_q[SLOT_W-1:0];
	assign tidx = task_q[SLOT_W-1:0];
	assign handle_ok = ({28'd0, task_q} < 32'(TASK_SLOTS)) && in_use_q[tidx];
	assign mode_free = (op_q == OP_CREATE);
	assign target_q = (op_q == OP_EXIT) ? Q_RUN : {1'b0, qsel_q};
	assign param_bad = chk_q && (entry_q == '0 || sbase_q == '0 || slen_q == '0 ||
		pri_q < pmin_q || pri_q > pmax_q);

	always_comb begin
		sc.clear = (state_q == S_IDLE) || (state_q == S_DONE);
		sc.load = (state_q == S_SCAN);
		sc.idx = sidx;
		sc.in_use = in_use_q[sidx];
		sc.queue = queue_q[sidx];
		sc.prio = prio_q[sidx];
		sc.older_bit = older_q[sidx][sr.best];
	end

	rtpq_scan u_scan (
		.clk(clk), .arst_n(arst_n), .mode_free(mode_free),
		.target_q(target_q), .ctl(sc), .res(sr)
	);

	assign busy = (state_q == S_SCAN) || (state_q == S_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_q <= 1'b1;
			pmin_q <= 8'd0;
			pmax_q <= 8'd255;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHECK: chk_q <= cfg_data[0];
				CFG_PMIN:  pmin_q <= cfg_data;
				CFG_PMAX:  pmax_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q <= op;
			task_q <= task_index;
			qsel_q <= queue_select;
			pri_q <= priority_req;
			entry_q <= entry_address;
			slen_q <= stack_length;
			sbase_q <= stack_base;
		end
	end

	// Task table and sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		logic [SLOT_W-1:0] s;
		logic [2:0] nq;
		logic put;
		logic [1:0] st;
		logic [3:0] rt;
		logic rv;
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			err_q <= ST_OK;
			done <= 1'b0;
			status <= ST_OK;
			result_task <= '0;
			result_valid <= 1'b0;
			last_error <= ST_OK;
			in_use_q <= '0;
			for (int i = 0; i < TASK_SLOTS; i++) begin
				prio_q[i] <= '0;
				queue_q[i] <= Q_NONE;
				older_q[i] <= '0;
				sentry_q[i] <= '0;
				sslen_q[i] <= '0;
				ssbase_q[i] <= '0;
			end
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE, S_DONE: begin
					if (start) begin
						cnt_q <= '0;
						if (op == OP_CREATE || op == OP_EXIT || op == OP_DEQ) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_EXEC;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(TASK_SLOTS - 1)) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					s = sr.best;
					nq = Q_NONE;
					put = 1'b0;
					st = ST_OK;
					rt = '0;
					rv = 1'b0;
					case (op_q)
						OP_CREATE: begin
							if (param_bad) begin
								st = ST_PARAM;
							end else if (!sr.found) begin
								st = ST_NOSLOT;
							end else begin
								in_use_q[s] <= 1'b1;
								prio_q[s] <= pri_q;
								sentry_q[s] <= entry_q;
								sslen_q[s] <= slen_q;
								ssbase_q[s] <= sbase_q;
								put = 1'b1;
								nq = Q_DORMANT;
								rt = 4'(s);
								rv = 1'b1;
							end
							err_q <= st;
						end
						OP_START: begin
							s = tidx;
							if (!handle_ok) begin
								st = ST_HANDLE;
							end else if (queue_q[s] != Q_DORMANT) begin
								st = ST_PARAM;
							end else begin
								put = 1'b1;
								nq = Q_READY;
							end
							err_q <= st;
						end
						OP_STOP: begin
							s = tidx;
							if (!handle_ok) begin
								st = ST_HANDLE;
							end else begin
								put = 1'b1;
								nq = Q_DORMANT;
							end
							err_q <= st;
						end
						OP_EXIT: begin
							if (!sr.found) begin
								st = ST_HANDLE;
							end else begin
								in_use_q[s] <= 1'b0;
								prio_q[s] <= '0;
								queue_q[s] <= Q_NONE;
								older_q[s] <= '0;
								sentry_q[s] <= '0;
								sslen_q[s] <= '0;
								ssbase_q[s] <= '0;
							end
							err_q <= st;
						end
						OP_ENQ: begin
							s = tidx;
							if (!handle_ok) begin
								st = ST_HANDLE;
							end else begin
								put = 1'b1;
								nq = {1'b0, qsel_q};
							end
						end
						OP_DEQ: begin
							if (sr.found) begin
								queue_q[s] <= Q_NONE;
								rt = 4'(s);
								rv = 1'b1;
							end
						end
						OP_REMOVE: begin
							s = tidx;
							if (!handle_ok) begin
								st = ST_HANDLE;
							end else if (queue_q[s] == {1'b0, qsel_q}) begin
								queue_q[s] <= Q_NONE;
								rt = task_q;
								rv = 1'b1;
							end
						end
						default: ;
					endcase
					if (put) begin
						for (int j = 0; j < TASK_SLOTS; j++) begin
							if (SLOT_W'(j) == s) begin
								older_q[j] <= '0;
							end else begin
								older_q[j][s] <= 1'b1;
							end
						end
						queue_q[s] <= nq;
					end
					status <= st;
					result_task <= rt;
					result_valid <= rv;
					last_error <= (op_q == OP_CREATE || op_q == OP_START ||
						op_q == OP_STOP || op_q == OP_EXIT) ? st : err_q;
					done <= 1'b1;
					state_q <= S_DONE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/core/rtpq_checker.sv
// Port-level checker for the task priority queue manager, bound to the top.
// Depends on rtpq_pkg.
module rtpq_checker import rtpq_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status,
	input logic [3:0] result_task,
	input logic       result_valid
);
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted beat did not raise busy");
	a_no_double_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result beat repeated");
	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result_valid) |-> (status == ST_OK)) else $error("valid with error");
	a_task_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result_valid) |-> (result_task == '0)) else $error("stray task");
endmodule

bind rtos_task_priority_queue_manager_unit rtpq_checker u_rtpq_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .result_task(result_task), .result_valid(result_valid)
);
